// ===== hdl/byte_stack_with_rotate_assert.svh =====
// Assertion macros used by the byte stack sequencer.
`ifndef BYTE_STACK_WITH_ROTATE_ASSERT_SVH
`define BYTE_STACK_WITH_ROTATE_ASSERT_SVH
`ifndef SYNTH
// Same-cycle implication check.
`define BSWR_ASSERT_IMPLY(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("byte stack assertion failed");
// Next-cycle implication check.
`define BSWR_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("byte stack assertion failed");
`else
`define BSWR_ASSERT_IMPLY(lbl, ck, rs, ante, cons)
`define BSWR_ASSERT_NEXT(lbl, ck, rs, ante, cons)
`endif
`endif

// ===== hdl/bswr_pkg.sv =====
// Types and codes for the byte stack with rotate.
`timescale 1ns / 1ps
package bswr_pkg;

  // action codes
  localparam logic [2:0] ACT_PUSH  = 3'd0;
  localparam logic [2:0] ACT_POP   = 3'd1;
  localparam logic [2:0] ACT_PEEK  = 3'd2;
  localparam logic [2:0] ACT_DUP   = 3'd3;
  localparam logic [2:0] ACT_ROTU  = 3'd4;
  localparam logic [2:0] ACT_ROTD  = 3'd5;
  localparam logic [2:0] ACT_PRINT = 3'd6;

  // status codes
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;
  localparam logic [1:0] STAT_DEPTH = 2'd3;

  localparam logic [6:0] CAPACITY_RESET = 7'd64;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] data;
    logic [6:0] rotate_depth;
  } bswr_in_t;

  typedef struct packed {
    logic [7:0] value;
    logic [1:0] status;
    logic       last;
  } bswr_out_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_LOAD,
    S_ROT_HOLD,
    S_ROT_MOVE,
    S_ROT_END,
    S_PR_WAIT,
    S_EMIT
  } bswr_state_t;

endpackage

// ===== hdl/byte_stack_with_rotate.sv =====
// Byte stack with dup and rotate: top level joining sequencer and stack memory.
// From input transaction to result register load: push, rotate by depth under two
//   and failed checks go from exec straight to emit; pop, peek, dup pass a load
//   state; rotate by depth k (k >= 2) moves entries one by one; print of n entries
//   loads one result each. One item at a time: the next input is taken after its
//   last result load, later when the result side stalls. Synchronous reset empties the stack, capacity 64.
`timescale 1ns / 1ps
module byte_stack_with_rotate
  import bswr_pkg::*;
#(
  parameter int MAX_DEPTH = 64
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      cfg_we,
  input  logic [6:0] cfg_data,
  input  logic      in_valid,
  output logic      in_ready,
  input  bswr_in_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output bswr_out_t out_item
);

  localparam int AW = $clog2(MAX_DEPTH);

  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [7:0]    mem_wdata, mem_rdata;

  // sequencer
  bswr_ctrl #(
    .MAX_DEPTH (MAX_DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  // stack storage
  bswr_ram #(
    .WIDTH (8),
    .DEPTH (MAX_DEPTH)
  ) u_stack_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

// ===== hdl/bswr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module bswr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port, holds when idle
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/bswr_ctrl.sv =====
// Stack sequencer: fill level, capacity register, memory access and result register.
`timescale 1ns / 1ps
`include "byte_stack_with_rotate_assert.svh"
module bswr_ctrl
  import bswr_pkg::*;
#(
  parameter int MAX_DEPTH = 64
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [6:0]                   cfg_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  bswr_in_t                     in_item,
  output logic                         out_valid,
  input  logic                         out_ready,
  output bswr_out_t                    out_item,
  output logic                         mem_we,
  output logic [$clog2(MAX_DEPTH)-1:0] mem_waddr,
  output logic [7:0]                   mem_wdata,
  output logic                         mem_re,
  output logic [$clog2(MAX_DEPTH)-1:0] mem_raddr,
  input  logic [7:0]                   mem_rdata
);

  localparam int AW   = $clog2(MAX_DEPTH);
  localparam int FW   = $clog2(MAX_DEPTH + 1);
  localparam int CMPW = (FW > 7) ? FW : 7;

  bswr_state_t state, state_next;

  logic [6:0]    capacity;
  logic [2:0]    act;
  logic [7:0]    dat;
  logic [6:0]    kq;
  logic [FW-1:0] fill, fill_next;
  logic [AW-1:0] idx, idx_next;
  logic [7:0]    tmp, tmp_next;
  logic [7:0]    res_value, res_value_next;
  logic [1:0]    res_status, res_status_next;
  logic          res_last, res_last_next;

  logic [CMPW-1:0] fill_ext, k_ext, cap_ext, base_w;
  logic [FW-1:0]   fill_m1;
  logic [AW-1:0]   top_addr, base_a, idx_m1, idx_p1;
  logic            is_full, is_empty, k_over, k_small, rot_up, rot_done, emit_go;

  // condition flags
  assign fill_ext = CMPW'(fill);
  assign k_ext    = CMPW'(kq);
  assign cap_ext  = CMPW'(capacity);
  assign base_w   = fill_ext - k_ext;
  assign base_a   = base_w[AW-1:0];
  assign fill_m1  = fill - FW'(1);
  assign top_addr = fill_m1[AW-1:0];
  assign idx_m1   = idx - AW'(1);
  assign idx_p1   = idx + AW'(1);
  assign is_full  = (fill_ext >= cap_ext) || (fill == FW'(MAX_DEPTH));
  assign is_empty = (fill == '0);
  assign k_over   = (k_ext > fill_ext);
  assign k_small  = (kq < 7'd2);
  assign rot_up   = (act == ACT_ROTU);
  assign rot_done = rot_up ? (idx_m1 == base_a) : (idx_p1 == top_addr);
  assign emit_go  = (state == S_EMIT) && (!out_valid || out_ready);
  assign in_ready = (state == S_IDLE);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        case (act)
          ACT_POP, ACT_PEEK: state_next = is_empty ? S_EMIT : S_LOAD;
          ACT_DUP:           state_next = (is_full || is_empty) ? S_EMIT : S_LOAD;
          ACT_ROTU, ACT_ROTD: state_next = (k_over || k_small) ? S_EMIT : S_ROT_HOLD;
          ACT_PRINT:         state_next = is_empty ? S_EMIT : S_PR_WAIT;
          default:           state_next = S_EMIT;
        endcase
      end
      S_LOAD:     state_next = S_EMIT;
      S_ROT_HOLD: state_next = S_ROT_MOVE;
      S_ROT_MOVE: state_next = rot_done ? S_ROT_END : S_ROT_MOVE;
      S_ROT_END:  state_next = S_EMIT;
      S_PR_WAIT:  state_next = S_EMIT;
      S_EMIT: begin
        if (emit_go) state_next = res_last ? S_IDLE : S_PR_WAIT;
      end
      default:    state_next = S_IDLE;
    endcase
  end

  // memory access and datapath updates
  always_comb begin
    mem_we          = 1'b0;
    mem_waddr       = fill[AW-1:0];
    mem_wdata       = dat;
    mem_re          = 1'b0;
    mem_raddr       = top_addr;
    fill_next       = fill;
    idx_next        = idx;
    tmp_next        = tmp;
    res_value_next  = res_value;
    res_status_next = res_status;
    res_last_next   = res_last;
    case (state)
      S_EXEC: begin
        res_value_next  = 8'd0;
        res_status_next = STAT_OK;
        res_last_next   = 1'b1;
        case (act)
          ACT_PUSH: begin
            if (is_full) begin
              res_status_next = STAT_FULL;
            end else begin
              mem_we    = 1'b1;
              fill_next = fill + FW'(1);
            end
          end
          ACT_POP, ACT_PEEK: begin
            if (is_empty) res_status_next = STAT_EMPTY;
            else mem_re = 1'b1;
          end
          ACT_DUP: begin
            if (is_full) res_status_next = STAT_FULL;
            else if (is_empty) res_status_next = STAT_EMPTY;
            else mem_re = 1'b1;
          end
          ACT_ROTU, ACT_ROTD: begin
            if (k_over) begin
              res_status_next = STAT_DEPTH;
            end else if (!k_small) begin
              // fetch the entry that moves as a whole
              mem_re    = 1'b1;
              mem_raddr = rot_up ? top_addr : base_a;
              idx_next  = rot_up ? top_addr : base_a;
            end
          end
          ACT_PRINT: begin
            if (!is_empty) begin
              mem_re   = 1'b1;
              idx_next = top_addr;
            end
          end
          default: ;
        endcase
      end
      S_LOAD: begin
        case (act)
          ACT_POP: begin
            res_value_next = mem_rdata;
            fill_next      = fill_m1;
          end
          ACT_PEEK: res_value_next = mem_rdata;
          default: begin
            // dup: copy top into the next free entry
            mem_we    = 1'b1;
            mem_wdata = mem_rdata;
            fill_next = fill + FW'(1);
          end
        endcase
      end
      S_ROT_HOLD: begin
        tmp_next  = mem_rdata;
        mem_re    = 1'b1;
        mem_raddr = rot_up ? idx_m1 : idx_p1;
      end
      S_ROT_MOVE: begin
        // shift one entry per cycle, next read overlaps the write
        mem_we    = 1'b1;
        mem_waddr = idx;
        mem_wdata = mem_rdata;
        idx_next  = rot_up ? idx_m1 : idx_p1;
        if (!rot_done) begin
          mem_re    = 1'b1;
          mem_raddr = rot_up ? (idx - AW'(2)) : (idx + AW'(2));
        end
      end
      S_ROT_END: begin
        mem_we    = 1'b1;
        mem_waddr = idx;
        mem_wdata = tmp;
      end
      S_PR_WAIT: begin
        res_value_next  = mem_rdata;
        res_status_next = STAT_OK;
        res_last_next   = (idx == '0);
      end
      S_EMIT: begin
        if (emit_go && !res_last) begin
          mem_re    = 1'b1;
          mem_raddr = idx_m1;
          idx_next  = idx_m1;
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fill      <= '0;
      capacity  <= CAPACITY_RESET;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      fill  <= fill_next;
      if (cfg_we) capacity <= cfg_data;
      if (emit_go) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      act <= in_item.action;
      dat <= in_item.data;
      kq  <= in_item.rotate_depth;
    end
    idx        <= idx_next;
    tmp        <= tmp_next;
    res_value  <= res_value_next;
    res_status <= res_status_next;
    res_last   <= res_last_next;
    if (emit_go) begin
      out_item.value  <= res_value;
      out_item.status <= res_status;
      out_item.last   <= res_last;
    end
  end

  `BSWR_ASSERT_IMPLY(a_fill_bound, clk, rst, 1'b1, fill <= FW'(MAX_DEPTH))
  `BSWR_ASSERT_IMPLY(a_no_rw_clash, clk, rst, mem_we && mem_re, mem_waddr != mem_raddr)
  `BSWR_ASSERT_NEXT(a_push_grows, clk, rst, state == S_EXEC && act == ACT_PUSH && !is_full, fill == $past(fill) + FW'(1))

endmodule
